>>> src/clist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clist_pkg : shared types, codes and microcode for the compact record list
// Transfer payloads, record layout, operation and status codes, and the
// read-only control store that drives the list sequencer.
// ----------------------------------------------------------------------------
package clist_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int INDEX_W        = 5;
    localparam int COUNT_OUT_W    = 6;

    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_DELETE = 3'd1,
        K_READ   = 3'd2,
        K_WRITE  = 3'd3,
        K_SEARCH = 3'd4,
        K_CLEAR  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         kind;
        logic [INDEX_W-1:0] index;
        logic [15:0]        food_id;
        logic [15:0]        cook_time;
        logic [15:0]        stay_time;
        logic [31:0]        cost;
    } t_in;

    typedef struct packed {
        logic [1:0]             status;
        logic                   found;
        logic [COUNT_OUT_W-1:0] count;
        logic [15:0]            read_id;
        logic [15:0]            read_cook;
        logic [15:0]            read_stay;
        logic [31:0]            read_cost;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] cook;
        logic [15:0] stay;
        logic [31:0] cost;
    } t_rec;

    // datapath actions, one per control word
    typedef enum logic [3:0] {
        A_NONE,
        A_INS_CHK,
        A_IDX_CHK,
        A_RD_PTR_M1,
        A_WR_PTR_DEC,
        A_WR_NEW_INC,
        A_RD_PTR_P1,
        A_WR_PTR_INC,
        A_CNT_DEC,
        A_RD_IDX,
        A_CAPTURE,
        A_WR_NEW,
        A_PTR_ZERO,
        A_RD_PTR,
        A_CMP_INC,
        A_DONE_CNT_ZERO
    } t_act;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_ACCEPT,
        C_ERR,
        C_PTR_EQ_IDX,
        C_PTR1_GE_CNT,
        C_PTR_GE_CNT
    } t_cond;

    typedef enum logic [4:0] {
        U_IDLE     = 5'd0,
        U_INS_CHK  = 5'd1,
        U_INS_LOOP = 5'd2,
        U_INS_RD   = 5'd3,
        U_INS_WR   = 5'd4,
        U_INS_PUT  = 5'd5,
        U_DEL_CHK  = 5'd6,
        U_DEL_LOOP = 5'd7,
        U_DEL_RD   = 5'd8,
        U_DEL_WR   = 5'd9,
        U_DEL_END  = 5'd10,
        U_RD_CHK   = 5'd11,
        U_RD_RD    = 5'd12,
        U_RD_CAP   = 5'd13,
        U_WR_CHK   = 5'd14,
        U_WR_PUT   = 5'd15,
        U_SR_INIT  = 5'd16,
        U_SR_LOOP  = 5'd17,
        U_SR_RD    = 5'd18,
        U_SR_CMP   = 5'd19,
        U_CLR      = 5'd20,
        U_FIN      = 5'd21
    } t_step;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        logic  wait_out;
        t_step target;
    } t_uword;

    // control store; the clear step shares its action code with nothing else
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{act: A_NONE, cond: C_ALWAYS, wait_out: 1'b0, target: U_IDLE};
        case (s)
            U_IDLE:     w = '{A_NONE,          C_ACCEPT,      1'b0, U_IDLE};
            U_INS_CHK:  w = '{A_INS_CHK,       C_ERR,         1'b0, U_FIN};
            U_INS_LOOP: w = '{A_NONE,          C_PTR_EQ_IDX,  1'b0, U_INS_PUT};
            U_INS_RD:   w = '{A_RD_PTR_M1,     C_NEXT,        1'b0, U_IDLE};
            U_INS_WR:   w = '{A_WR_PTR_DEC,    C_ALWAYS,      1'b0, U_INS_LOOP};
            U_INS_PUT:  w = '{A_WR_NEW_INC,    C_ALWAYS,      1'b0, U_FIN};
            U_DEL_CHK:  w = '{A_IDX_CHK,       C_ERR,         1'b0, U_FIN};
            U_DEL_LOOP: w = '{A_NONE,          C_PTR1_GE_CNT, 1'b0, U_DEL_END};
            U_DEL_RD:   w = '{A_RD_PTR_P1,     C_NEXT,        1'b0, U_IDLE};
            U_DEL_WR:   w = '{A_WR_PTR_INC,    C_ALWAYS,      1'b0, U_DEL_LOOP};
            U_DEL_END:  w = '{A_CNT_DEC,       C_ALWAYS,      1'b0, U_FIN};
            U_RD_CHK:   w = '{A_IDX_CHK,       C_ERR,         1'b0, U_FIN};
            U_RD_RD:    w = '{A_RD_IDX,        C_NEXT,        1'b0, U_IDLE};
            U_RD_CAP:   w = '{A_CAPTURE,       C_ALWAYS,      1'b0, U_FIN};
            U_WR_CHK:   w = '{A_IDX_CHK,       C_ERR,         1'b0, U_FIN};
            U_WR_PUT:   w = '{A_WR_NEW,        C_ALWAYS,      1'b0, U_FIN};
            U_SR_INIT:  w = '{A_PTR_ZERO,      C_NEXT,        1'b0, U_IDLE};
            U_SR_LOOP:  w = '{A_NONE,          C_PTR_GE_CNT,  1'b0, U_FIN};
            U_SR_RD:    w = '{A_RD_PTR,        C_NEXT,        1'b0, U_IDLE};
            U_SR_CMP:   w = '{A_CMP_INC,       C_ALWAYS,      1'b0, U_SR_LOOP};
            U_CLR:      w = '{A_DONE_CNT_ZERO, C_ALWAYS,      1'b0, U_FIN};
            U_FIN:      w = '{A_NONE,          C_ALWAYS,      1'b1, U_IDLE};
            default:    w = '{A_NONE,          C_ALWAYS,      1'b0, U_IDLE};
        endcase
        return w;
    endfunction

    // entry point of each operation's program
    function automatic t_step entry(input logic [2:0] kind);
        t_step s;
        case (kind)
            K_INSERT: s = U_INS_CHK;
            K_DELETE: s = U_DEL_CHK;
            K_READ:   s = U_RD_CHK;
            K_WRITE:  s = U_WR_CHK;
            K_SEARCH: s = U_SR_INIT;
            K_CLEAR:  s = U_CLR;
            default:  s = U_FIN;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> src/clist_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clist_ram : record store
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module clist_ram
    import clist_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire t_rec                     i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_rec                          o_rd_data
);

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> src/compact_list_insert_delete_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compact_list_insert_delete_search_top : ordered record list, shift insert
// Microcoded sequencer over a two-port record store; one result per item.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in): one transfer is one list
//   operation - insert, delete, read, overwrite, search by id, or clear.
//   Output channel (o_out_valid / i_out_stall / o_out): exactly one result
//   transfer per operation, in order: status, found flag, length after the
//   operation and the record read (zero unless a read succeeded).
//   Every record move is a read then a write of the record store through its
//   one read and one write port, plus one loop test step. The final step
//   registers the result, so o_out_valid rises as the sequencer returns to
//   its idle step, where the next input transfer can be taken.
//   o_in_stall is low only while the sequencer sits at its idle step.
//   Reset (i_rst_n low, synchronous) empties the list and drops o_out_valid.
//   The record store itself is not cleared; emptied entries are never read.
//   While i_out_stall holds a result, the block may take one more operation
//   and work on it, but waits at its final step until the old result leaves.
// ----------------------------------------------------------------------------
module compact_list_insert_delete_search_top
    import clist_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    localparam int AW   = $clog2(LIST_DEPTH);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

    // sequencer
    t_step  r_upc, n_upc;
    t_uword uw;
    t_step  step_inc;

    // datapath registers
    t_in           r_cmd,    n_cmd;
    logic [CW-1:0] r_cnt,    n_cnt;
    logic [CW-1:0] r_ptr,    n_ptr;
    logic [1:0]    r_status, n_status;
    logic          r_found,  n_found;
    t_rec          r_rd,     n_rd;
    logic          r_out_valid, n_out_valid;
    t_out          r_out,    n_out;

    // store ports
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_rec          wr_data, rd_data;

    logic            in_fire, out_busy, chk_err, full;
    logic [CMPW-1:0] idx_w, cnt_w, ptr_w;
    t_rec            new_rec;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_busy = r_out_valid && i_out_stall;

    assign idx_w = CMPW'(r_cmd.index);
    assign cnt_w = CMPW'(r_cnt);
    assign ptr_w = CMPW'(r_ptr);
    assign full  = (r_cnt == CW'(LIST_DEPTH));

    assign new_rec = '{id: r_cmd.food_id, cook: r_cmd.cook_time,
                       stay: r_cmd.stay_time, cost: r_cmd.cost};

    // control word fetch
    assign uw       = ucode(r_upc);
    assign step_inc = t_step'(r_upc + 5'd1);

    // range and capacity checks of the current check step
    always_comb begin
        case (uw.act)
            A_INS_CHK: chk_err = (idx_w > cnt_w) || full;
            A_IDX_CHK: chk_err = (idx_w >= cnt_w);
            default:   chk_err = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        n_upc = r_upc;
        if (uw.wait_out && out_busy) begin
            n_upc = r_upc;
        end else begin
            case (uw.cond)
                C_ALWAYS:      n_upc = uw.target;
                C_ACCEPT:      n_upc = in_fire ? entry(i_in.kind) : r_upc;
                C_ERR:         n_upc = chk_err ? uw.target : step_inc;
                C_PTR_EQ_IDX:  n_upc = (ptr_w == idx_w) ? uw.target : step_inc;
                C_PTR1_GE_CNT: n_upc = ((ptr_w + CMPW'(1)) >= cnt_w) ? uw.target : step_inc;
                C_PTR_GE_CNT:  n_upc = (ptr_w >= cnt_w) ? uw.target : step_inc;
                default:       n_upc = step_inc;
            endcase
        end
    end

    // datapath actions
    always_comb begin
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_status    = r_status;
        n_found     = r_found;
        n_rd        = r_rd;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        wr_en       = 1'b0;
        wr_addr     = AW'(r_ptr);
        wr_data     = rd_data;
        rd_en       = 1'b0;
        rd_addr     = AW'(r_ptr);

        if (in_fire) begin
            n_cmd    = i_in;
            n_status = ST_OK;
            n_found  = 1'b0;
            n_rd     = '0;
        end

        case (uw.act)
            A_INS_CHK: begin
                n_ptr = r_cnt;
                if (idx_w > cnt_w) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end
            end
            A_IDX_CHK: begin
                n_ptr = CW'(r_cmd.index);
                if (idx_w >= cnt_w) begin
                    n_status = ST_RANGE;
                end
            end
            A_RD_PTR_M1: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_ptr - CW'(1));
            end
            A_WR_PTR_DEC: begin
                wr_en = 1'b1;
                n_ptr = r_ptr - CW'(1);
            end
            A_WR_NEW_INC: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_cmd.index);
                wr_data = new_rec;
                n_cnt   = r_cnt + CW'(1);
            end
            A_RD_PTR_P1: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_ptr + CW'(1));
            end
            A_WR_PTR_INC: begin
                wr_en = 1'b1;
                n_ptr = r_ptr + CW'(1);
            end
            A_CNT_DEC: begin
                n_cnt = r_cnt - CW'(1);
            end
            A_RD_IDX: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_cmd.index);
            end
            A_CAPTURE: begin
                n_rd = rd_data;
            end
            A_WR_NEW: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_cmd.index);
                wr_data = new_rec;
            end
            A_PTR_ZERO: begin
                n_ptr = '0;
            end
            A_RD_PTR: begin
                rd_en = 1'b1;
            end
            A_CMP_INC: begin
                if (rd_data.id == r_cmd.food_id) begin
                    n_found = 1'b1;
                end
                n_ptr = r_ptr + CW'(1);
            end
            A_DONE_CNT_ZERO: begin
                n_cnt = '0;
            end
            default: begin
            end
        endcase

        // final step: hand the result to the output register
        if (uw.wait_out && !out_busy) begin
            n_out_valid = 1'b1;
            n_out = '{status:    r_status,
                      found:     r_found,
                      count:     COUNT_OUT_W'(r_cnt),
                      read_id:   r_rd.id,
                      read_cook: r_rd.cook,
                      read_stay: r_rd.stay,
                      read_cost: r_rd.cost};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= U_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ptr    <= n_ptr;
        r_status <= n_status;
        r_found  <= n_found;
        r_rd     <= n_rd;
        r_out    <= n_out;
    end

    clist_ram #(
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall  = (r_upc != U_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // length never passes the capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(LIST_DEPTH))
        else $error("list length above capacity");

    // a successful insert grows the list by exactly one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc == U_INS_PUT |=> r_cnt == $past(r_cnt) + CW'(1))
        else $error("insert did not grow list by one");

    // shift and search pointer never passes the list length at the loop steps
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == U_INS_LOOP || r_upc == U_DEL_LOOP || r_upc == U_SR_LOOP)
        |-> r_ptr <= r_cnt)
        else $error("shift pointer beyond list length");

    // a new result only comes from the final step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_upc) == U_FIN)
        else $error("result raised outside final step");

    // store is never written while the block is idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc == U_IDLE |-> !wr_en && !rd_en)
        else $error("store access at idle step");

endmodule
`default_nettype wire
